[rtl/core/stsr_pkg.sv]
// ----------------------------------------------------------------------------
// stsr_pkg
// Shared types and constants for the throttle and steering slew block: field
// widths, reset values of the setup registers, register indexes, payload
// structs and the request struct of the bit-serial multiply-divide unit.
// ----------------------------------------------------------------------------
package stsr_pkg;

    localparam int FRACTION_BITS = 8;

    localparam int POS_W      = 15;
    localparam int SPAN_W     = 14;
    localparam int INC_W      = 12;
    localparam int RAW_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // 100 % full scale
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(100 << FRACTION_BITS);
    localparam logic [RAW_W-1:0] RAW_MID = RAW_W'(50);

    localparam logic [POS_W-1:0]  IDLE_T_RST = POS_W'(50 << FRACTION_BITS);
    localparam logic [POS_W-1:0]  IDLE_S_RST = POS_W'(49 << FRACTION_BITS);
    localparam logic [SPAN_W-1:0] TSPAN_RST  = SPAN_W'(9 << FRACTION_BITS);
    localparam logic [SPAN_W-1:0] DBAND_RST  = SPAN_W'(9 << FRACTION_BITS);
    localparam logic [SPAN_W-1:0] SSPAN_RST  = SPAN_W'(12 << FRACTION_BITS);
    localparam logic [INC_W-1:0]  TINC_RST   = INC_W'(((1 << FRACTION_BITS) + 5) / 10);
    localparam logic [INC_W-1:0]  SINC_RST   = INC_W'(((18 << FRACTION_BITS) + 5) / 10);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THROTTLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_STEERING      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_SPAN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_DEAD_BAND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEERING_SPAN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_INCREMENT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEERING_INCREMENT = 3'd6;

    // multiply-divide unit widths
    localparam int MD_A_W = 16;   // multiplicand
    localparam int MD_B_W = 15;   // multiplier, one bit per cycle
    localparam int MD_D_W = 18;   // divisor
    localparam int MD_P_W = 31;   // product / dividend, one quotient bit per cycle
    localparam int MD_Q_W = 15;   // quotient bits kept

    typedef struct packed {
        logic [MD_A_W-1:0] mcand;
        logic [MD_B_W-1:0] mplier;
        logic [MD_D_W-1:0] divisor;
    } t_md_req;

    typedef struct packed {
        logic [RAW_W-1:0] raw_steering;
        logic [RAW_W-1:0] raw_throttle;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0] throttle_position;
        logic [POS_W-1:0] steering_position;
        logic             throttle_moved;
        logic             steering_moved;
        logic             steering_release;
    } t_out_item;

endpackage

[rtl/core/stsr_muldiv.sv]
// ----------------------------------------------------------------------------
// stsr_muldiv
// Bit-serial unsigned (a * b) / d. Shift-add multiply, one multiplier bit per
// cycle, then restoring division, one quotient bit per cycle. o_done pulses
// for one cycle with the floor quotient on o_quot.
// ----------------------------------------------------------------------------
module stsr_muldiv
    import stsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_md_req           i_req,
    output logic              o_done,
    output logic [MD_Q_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(MD_P_W);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    logic [1:0]        r_phase,  n_phase;
    logic [CNT_W-1:0]  r_cnt,    n_cnt;
    logic              r_done,   n_done;
    logic [MD_P_W-1:0] r_mcand,  n_mcand;
    logic [MD_B_W-1:0] r_mplier, n_mplier;
    logic [MD_P_W-1:0] r_acc,    n_acc;
    logic [MD_P_W-1:0] r_num,    n_num;
    logic [MD_D_W-1:0] r_rem,    n_rem;
    logic [MD_D_W-1:0] r_den,    n_den;

    logic [MD_P_W-1:0] acc_sum;
    logic [MD_D_W:0]   trial;
    logic [MD_D_W:0]   diff;
    logic              ge;
    logic [MD_D_W-1:0] rem_nx;

    assign acc_sum = r_mplier[0] ? r_acc + r_mcand : r_acc;
    assign trial   = {r_rem, r_num[MD_P_W-1]};
    assign ge      = trial >= {1'b0, r_den};
    assign diff    = trial - {1'b0, r_den};
    // remainder stays below the divisor, so it fits the divisor width
    assign rem_nx  = ge ? diff[MD_D_W-1:0] : trial[MD_D_W-1:0];

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        n_num    = r_num;
        n_rem    = r_rem;
        n_den    = r_den;
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_mcand  = MD_P_W'(i_req.mcand);
                    n_mplier = i_req.mplier;
                    n_acc    = '0;
                    n_den    = i_req.divisor;
                    n_cnt    = '0;
                    n_phase  = PH_MUL;
                end
            end
            PH_MUL: begin
                n_acc    = acc_sum;
                n_mcand  = {r_mcand[MD_P_W-2:0], 1'b0};
                n_mplier = {1'b0, r_mplier[MD_B_W-1:1]};
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MD_B_W - 1)) begin
                    n_num   = acc_sum;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_phase = PH_DIV;
                end
            end
            PH_DIV: begin
                n_rem = rem_nx;
                n_num = {r_num[MD_P_W-2:0], ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MD_P_W - 1)) begin
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
        r_num    <= n_num;
        r_rem    <= n_rem;
        r_den    <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_num[MD_Q_W-1:0];

endmodule

[rtl/core/servo_throttle_steering_ramp.sv]
// ----------------------------------------------------------------------------
// servo_throttle_steering_ramp
// Each transaction carries raw throttle and steering commands (50 = neutral).
// They map to target positions around the idle values; the held throttle and
// steering positions then slew towards them, with crossing, return-to-idle and
// dead-band rules. One result transaction per input transaction.
// ----------------------------------------------------------------------------
// Sequencing: a transaction is taken only in S_IDLE. Four jobs run one after
// another on a single bit-serial multiply-divide unit (throttle target,
// throttle step, steering target, steering step); each job works through the
// 15 multiplier bits and then the 31 quotient bits. The throttle update takes
// S_TU1 and S_TU2 before the steering step, and the steering update takes S_SU,
// which waits until the output register is free. A finished result sits in the
// output register, so the next transaction is taken while it waits. The user
// must write setup registers only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module servo_throttle_steering_ramp
    import stsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    localparam int SW = POS_W + 3;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_TT_GO   = 4'd1;
    localparam logic [3:0] S_TT_WAIT = 4'd2;
    localparam logic [3:0] S_TS_GO   = 4'd3;
    localparam logic [3:0] S_TS_WAIT = 4'd4;
    localparam logic [3:0] S_ST_GO   = 4'd5;
    localparam logic [3:0] S_ST_WAIT = 4'd6;
    localparam logic [3:0] S_TU1     = 4'd7;
    localparam logic [3:0] S_TU2     = 4'd8;
    localparam logic [3:0] S_SS_GO   = 4'd9;
    localparam logic [3:0] S_SS_WAIT = 4'd10;
    localparam logic [3:0] S_SU      = 4'd11;

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [SW-1:0] v);
        logic [POS_W-1:0] r;
        if (v < SW'(0))
            r = '0;
        else if (v > $signed({3'b000, POS_MAX}))
            r = POS_MAX;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    // setup registers
    logic [POS_W-1:0]  r_idle_t, n_idle_t;
    logic [POS_W-1:0]  r_idle_s, n_idle_s;
    logic [SPAN_W-1:0] r_tspan,  n_tspan;
    logic [SPAN_W-1:0] r_dband,  n_dband;
    logic [SPAN_W-1:0] r_sspan,  n_sspan;
    logic [INC_W-1:0]  r_tinc,   n_tinc;
    logic [INC_W-1:0]  r_sinc,   n_sinc;

    // held state and control
    logic [3:0]        r_state,     n_state;
    logic [POS_W-1:0]  r_thr,       n_thr;
    logic [POS_W-1:0]  r_str,       n_str;
    logic              r_settled,   n_settled;
    logic              r_out_valid, n_out_valid;

    // working payload
    logic [RAW_W-1:0]  r_raw_t,  n_raw_t;
    logic [RAW_W-1:0]  r_raw_s,  n_raw_s;
    logic [POS_W-1:0]  r_tgt_t,  n_tgt_t;
    logic [POS_W-1:0]  r_tgt_s,  n_tgt_s;
    logic [INC_W-1:0]  r_step_t, n_step_t;
    logic [13:0]       r_step_s, n_step_s;
    logic [POS_W-1:0]  r_cand,   n_cand;
    logic              r_t_up,   n_t_up;
    logic              r_t_dn,   n_t_dn;
    t_out_item         r_out,    n_out;

    // multiply-divide unit
    logic              md_start;
    t_md_req           md_req;
    logic              md_done;
    logic [MD_Q_W-1:0] md_quot;

    // target mapping
    logic                  is_tt;
    logic [RAW_W-1:0]      raw_sel;
    logic                  raw_neg;
    logic [RAW_W-1:0]      raw_dev;
    logic [SPAN_W-1:0]     span_sel;
    logic [POS_W-1:0]      idle_sel;
    logic signed [SW-1:0]  tgt_sum;
    logic [POS_W-1:0]      tgt_new;

    // throttle step
    logic signed [16:0]    t_diff;
    logic [POS_W-1:0]      t_dev;
    logic signed [16:0]    t_num;
    logic                  t_zero;
    logic [MD_A_W-1:0]     tinc10;
    logic [MD_D_W-1:0]     tspan11;

    // steering step
    logic [POS_W-1:0]      s_den2;
    logic signed [16:0]    s_num;
    logic [MD_B_W-1:0]     s_num_u;
    logic [MD_D_W-1:0]     s_div;
    logic                  s_up;
    logic                  s_dn;
    logic                  s_cross;
    logic [13:0]           sinc3;

    // throttle update
    logic                  tu_up;
    logic                  tu_dn;
    logic                  tu_cross;
    logic [POS_W-1:0]      tinc5;
    logic [POS_W-1:0]      tinc3;
    logic [POS_W-1:0]      tu_delta;
    logic signed [16:0]    tu_sum;
    logic [POS_W-1:0]      tu_cand;
    logic signed [SW-1:0]  db_hi;
    logic signed [SW-1:0]  db_lo;
    logic                  jump_up;
    logic                  jump_dn;
    logic [POS_W-1:0]      thr_fin;

    // steering update
    logic signed [16:0]    su_sum;
    logic [POS_W-1:0]      str_fin;
    logic                  release_s;
    logic                  out_free;

    stsr_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_req   (md_req),
        .o_done  (md_done),
        .o_quot  (md_quot)
    );

    // ---- target: idle +/- |raw - 50| * span / 50, saturated ----
    assign is_tt    = (r_state == S_TT_GO) || (r_state == S_TT_WAIT);
    assign raw_sel  = is_tt ? r_raw_t : r_raw_s;
    assign raw_neg  = raw_sel < RAW_MID;
    assign raw_dev  = raw_neg ? RAW_MID - raw_sel : raw_sel - RAW_MID;
    assign span_sel = is_tt ? r_tspan : r_sspan;
    assign idle_sel = is_tt ? r_idle_t : r_idle_s;
    assign tgt_sum  = raw_neg ? $signed({3'b000, idle_sel}) - $signed({3'b000, md_quot})
                              : $signed({3'b000, idle_sel}) + $signed({3'b000, md_quot});
    assign tgt_new  = sat_pos(tgt_sum);

    // ---- throttle deflection from idle ----
    assign t_diff  = $signed({2'b00, r_thr}) - $signed({2'b00, r_idle_t});
    assign t_dev   = t_diff[16] ? POS_W'(-t_diff) : t_diff[POS_W-1:0];
    assign t_num   = $signed({3'b000, r_tspan}) - $signed({2'b00, t_dev});
    assign t_zero  = (r_tspan == '0) || (t_num <= 17'sd0);
    assign tinc10  = MD_A_W'({r_tinc, 3'b000}) + MD_A_W'({r_tinc, 1'b0});
    assign tspan11 = MD_D_W'({r_tspan, 3'b000}) + MD_D_W'({r_tspan, 1'b0})
                   + MD_D_W'(r_tspan);

    // ---- steering scale (2*span - dev) / (2*span), uses updated throttle ----
    assign s_den2 = {r_tspan, 1'b0};
    assign s_num  = $signed({2'b00, s_den2}) - $signed({2'b00, t_dev});
    always_comb begin
        if (s_den2 == '0) begin
            s_num_u = MD_B_W'(t_dev == '0);
            s_div   = MD_D_W'(1);
        end else if (s_num < 17'sd0) begin
            s_num_u = '0;
            s_div   = MD_D_W'(s_den2);
        end else begin
            s_num_u = s_num[MD_B_W-1:0];
            s_div   = MD_D_W'(s_den2);
        end
    end
    assign s_up    = r_tgt_s > r_str;
    assign s_dn    = r_tgt_s < r_str;
    assign s_cross = (s_up && (r_str < r_idle_s) && (r_tgt_s > r_idle_s))
                  || (s_dn && (r_str > r_idle_s) && (r_tgt_s < r_idle_s));
    assign sinc3   = 14'(r_sinc) + 14'({r_sinc, 1'b0});

    // ---- unit requests ----
    always_comb begin
        md_start = 1'b0;
        md_req   = '0;
        case (r_state)
            S_TT_GO, S_ST_GO: begin
                md_start       = 1'b1;
                md_req.mcand   = MD_A_W'(span_sel);
                md_req.mplier  = MD_B_W'(raw_dev);
                md_req.divisor = MD_D_W'(RAW_MID);
            end
            S_TS_GO: begin
                md_start       = 1'b1;
                md_req.mcand   = tinc10;
                md_req.mplier  = t_zero ? '0 : MD_B_W'(t_num[SPAN_W-1:0]);
                md_req.divisor = t_zero ? MD_D_W'(1) : tspan11;
            end
            S_SS_GO: begin
                md_start       = 1'b1;
                md_req.mcand   = s_cross ? MD_A_W'(sinc3) : MD_A_W'(r_sinc);
                md_req.mplier  = s_num_u;
                md_req.divisor = s_div;
            end
            default: begin
                md_start = 1'b0;
            end
        endcase
    end

    // ---- throttle update, first half: step and clamp to target ----
    assign tu_up    = r_tgt_t > r_thr;
    assign tu_dn    = r_tgt_t < r_thr;
    assign tu_cross = (tu_up && (r_thr < r_idle_t) && (r_tgt_t > r_idle_t))
                   || (tu_dn && (r_thr > r_idle_t) && (r_tgt_t < r_idle_t));
    assign tinc5    = POS_W'(r_tinc) + POS_W'({r_tinc, 2'b00});
    assign tinc3    = POS_W'(r_tinc) + POS_W'({r_tinc, 1'b0});
    assign tu_delta = tu_cross ? tinc5
                    : (r_tgt_t == r_idle_t) ? tinc3 : POS_W'(r_step_t);
    assign tu_sum   = tu_up ? $signed({2'b00, r_thr}) + $signed({2'b00, tu_delta})
                            : $signed({2'b00, r_thr}) - $signed({2'b00, tu_delta});
    always_comb begin
        if (tu_up)
            tu_cand = (tu_sum > $signed({2'b00, r_tgt_t})) ? r_tgt_t : tu_sum[POS_W-1:0];
        else if (tu_dn)
            tu_cand = (tu_sum < $signed({2'b00, r_tgt_t})) ? r_tgt_t : tu_sum[POS_W-1:0];
        else
            tu_cand = r_thr;
    end

    // ---- throttle update, second half: dead band jump and saturation ----
    assign db_hi   = $signed({3'b000, r_idle_t}) + $signed({4'b0000, r_dband});
    assign db_lo   = $signed({3'b000, r_idle_t}) - $signed({4'b0000, r_dband});
    assign jump_up = r_t_up && (r_tgt_t > r_idle_t) && (r_cand > r_idle_t)
                  && ($signed({3'b000, r_cand}) < db_hi);
    assign jump_dn = r_t_dn && (r_tgt_t < r_idle_t) && (r_cand < r_idle_t)
                  && ($signed({3'b000, r_cand}) > db_lo);
    assign thr_fin = sat_pos(jump_up ? db_hi : jump_dn ? db_lo : $signed({3'b000, r_cand}));

    // ---- steering update ----
    assign su_sum = s_up ? $signed({2'b00, r_str}) + $signed({3'b000, r_step_s})
                         : $signed({2'b00, r_str}) - $signed({3'b000, r_step_s});
    always_comb begin
        if (s_up)
            str_fin = (su_sum > $signed({2'b00, r_tgt_s})) ? r_tgt_s : su_sum[POS_W-1:0];
        else if (s_dn)
            str_fin = (su_sum < $signed({2'b00, r_tgt_s})) ? r_tgt_s : su_sum[POS_W-1:0];
        else
            str_fin = r_str;
    end
    assign release_s = !s_up && !s_dn && !r_settled;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // ---- sequencer ----
    always_comb begin
        n_idle_t    = r_idle_t;
        n_idle_s    = r_idle_s;
        n_tspan     = r_tspan;
        n_dband     = r_dband;
        n_sspan     = r_sspan;
        n_tinc      = r_tinc;
        n_sinc      = r_sinc;
        n_state     = r_state;
        n_thr       = r_thr;
        n_str       = r_str;
        n_settled   = r_settled;
        n_out_valid = r_out_valid;
        n_raw_t     = r_raw_t;
        n_raw_s     = r_raw_s;
        n_tgt_t     = r_tgt_t;
        n_tgt_s     = r_tgt_s;
        n_step_t    = r_step_t;
        n_step_s    = r_step_s;
        n_cand      = r_cand;
        n_t_up      = r_t_up;
        n_t_dn      = r_t_dn;
        n_out       = r_out;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDLE_THROTTLE:      n_idle_t = i_cfg_data[POS_W-1:0];
                CFG_IDLE_STEERING:      n_idle_s = i_cfg_data[POS_W-1:0];
                CFG_THROTTLE_SPAN:      n_tspan  = i_cfg_data[SPAN_W-1:0];
                CFG_THROTTLE_DEAD_BAND: n_dband  = i_cfg_data[SPAN_W-1:0];
                CFG_STEERING_SPAN:      n_sspan  = i_cfg_data[SPAN_W-1:0];
                CFG_THROTTLE_INCREMENT: n_tinc   = i_cfg_data[INC_W-1:0];
                CFG_STEERING_INCREMENT: n_sinc   = i_cfg_data[INC_W-1:0];
                default: begin
                end
            endcase
        end

        if (r_out_valid && i_out_ready)
            n_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_raw_t = i_in_data.raw_throttle;
                    n_raw_s = i_in_data.raw_steering;
                    n_state = S_TT_GO;
                end
            end
            S_TT_GO:   n_state = S_TT_WAIT;
            S_TT_WAIT: begin
                if (md_done) begin
                    n_tgt_t = tgt_new;
                    n_state = S_TS_GO;
                end
            end
            S_TS_GO:   n_state = S_TS_WAIT;
            S_TS_WAIT: begin
                if (md_done) begin
                    n_step_t = md_quot[INC_W-1:0];
                    n_state  = S_ST_GO;
                end
            end
            S_ST_GO:   n_state = S_ST_WAIT;
            S_ST_WAIT: begin
                if (md_done) begin
                    n_tgt_s = tgt_new;
                    n_state = S_TU1;
                end
            end
            S_TU1: begin
                n_cand  = tu_cand;
                n_t_up  = tu_up;
                n_t_dn  = tu_dn;
                n_state = S_TU2;
            end
            S_TU2: begin
                n_thr   = thr_fin;
                n_state = S_SS_GO;
            end
            S_SS_GO:   n_state = S_SS_WAIT;
            S_SS_WAIT: begin
                if (md_done) begin
                    n_step_s = md_quot[13:0];
                    n_state  = S_SU;
                end
            end
            S_SU: begin
                // commit only once the output register can take the result
                if (out_free) begin
                    n_str                   = str_fin;
                    n_settled               = !(s_up || s_dn);
                    n_out.throttle_position = r_thr;
                    n_out.steering_position = str_fin;
                    n_out.throttle_moved    = r_t_up || r_t_dn;
                    n_out.steering_moved    = s_up || s_dn;
                    n_out.steering_release  = release_s;
                    n_out_valid             = 1'b1;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_t    <= IDLE_T_RST;
            r_idle_s    <= IDLE_S_RST;
            r_tspan     <= TSPAN_RST;
            r_dband     <= DBAND_RST;
            r_sspan     <= SSPAN_RST;
            r_tinc      <= TINC_RST;
            r_sinc      <= SINC_RST;
            r_state     <= S_IDLE;
            r_thr       <= IDLE_T_RST;
            r_str       <= IDLE_S_RST;
            r_settled   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_idle_t    <= n_idle_t;
            r_idle_s    <= n_idle_s;
            r_tspan     <= n_tspan;
            r_dband     <= n_dband;
            r_sspan     <= n_sspan;
            r_tinc      <= n_tinc;
            r_sinc      <= n_sinc;
            r_state     <= n_state;
            r_thr       <= n_thr;
            r_str       <= n_str;
            r_settled   <= n_settled;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw_t  <= n_raw_t;
        r_raw_s  <= n_raw_s;
        r_tgt_t  <= n_tgt_t;
        r_tgt_s  <= n_tgt_s;
        r_step_t <= n_step_t;
        r_step_s <= n_step_s;
        r_cand   <= n_cand;
        r_t_up   <= n_t_up;
        r_t_dn   <= n_t_dn;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[verif/servo_throttle_steering_ramp_test.sv]
// ----------------------------------------------------------------------------
// servo_throttle_steering_ramp_test
// Self-checking bench for the throttle and steering slew block. Raw command
// pairs go in through a bursty valid/ready driver. A stalling receiver takes
// the results. Each result is checked field by field against a cycle-free
// slew calculation kept in step with the block. Setup registers are
// reprogrammed between phases (reset values, both range extremes, zero
// throttle span, idle beyond full scale, random settings). One phase holds
// off the receiver long enough to back the block up into its input.
// ----------------------------------------------------------------------------
module servo_throttle_steering_ramp_test;
    import stsr_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 250;
    localparam int HOLD_CYCLES    = 1600;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int MAX_REPORTS    = 200;

    localparam longint THR_CROSS_GAIN  = 5;
    localparam longint THR_RETURN_GAIN = 3;
    localparam longint STR_CROSS_GAIN  = 3;

    localparam logic [CFG_IDX_W-1:0] SETUP_ORDER [7] = '{
        CFG_IDLE_THROTTLE, CFG_IDLE_STEERING, CFG_THROTTLE_SPAN,
        CFG_THROTTLE_DEAD_BAND, CFG_STEERING_SPAN,
        CFG_THROTTLE_INCREMENT, CFG_STEERING_INCREMENT
    };

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    t_in_item              in_data    = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    t_out_item             out_data;

    servo_throttle_steering_ramp DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // setup shadow and slew state
    longint idle_thr  = longint'(IDLE_T_RST);
    longint idle_str  = longint'(IDLE_S_RST);
    longint thr_span  = longint'(TSPAN_RST);
    longint thr_band  = longint'(DBAND_RST);
    longint str_span  = longint'(SSPAN_RST);
    longint thr_inc   = longint'(TINC_RST);
    longint str_inc   = longint'(SINC_RST);
    longint thr_pos   = longint'(IDLE_T_RST);
    longint str_pos   = longint'(IDLE_S_RST);
    bit     str_settled = 1'b1;

    t_in_item  cmd_queue [$];
    t_out_item expected_positions [$];

    int errors      = 0;
    int reports     = 0;
    int n_cmds      = 0;
    int n_results   = 0;
    int n_thr_moves = 0;
    int n_str_moves = 0;
    int n_releases  = 0;
    int n_phases    = 0;

    logic     in_taken     = 1'b0;
    int       burst_left   = 0;
    int       gap_left     = 0;
    int       hold_asked   = 0;
    int       hold_done    = 0;
    int       hold_left    = 0;
    int       rx_left      = 0;
    t_rx_mode rx_mode      = RX_OPEN;
    int       quiet_cycles = 0;

    function automatic longint clamp_pct(longint v);
        if (v < 0) return 0;
        if (v > longint'(POS_MAX)) return longint'(POS_MAX);
        return v;
    endfunction

    // offset truncates toward zero, as SV signed division does
    function automatic longint aim_point(logic [RAW_W-1:0] raw, longint idle, longint span);
        longint prod;
        prod = (longint'(raw) - longint'(RAW_MID)) * span;
        return clamp_pct(idle + prod / longint'(RAW_MID));
    endfunction

    function automatic t_out_item slew_step(t_in_item cmd);
        longint    dev, num, den, step, tgt, cur;
        t_out_item r;
        r = '0;

        // throttle: step shrinks with distance from idle, 10/11 of the increment at idle
        dev = thr_pos - idle_thr;
        if (dev < 0) dev = -dev;
        num = thr_span - dev;
        if (thr_span == 0 || num <= 0) step = 0;
        else step = (thr_inc * 10 * num) / (11 * thr_span);

        tgt = aim_point(cmd.raw_throttle, idle_thr, thr_span);
        cur = thr_pos;
        if (tgt > cur) begin
            r.throttle_moved = 1'b1;
            if (cur < idle_thr && tgt > idle_thr) cur += thr_inc * THR_CROSS_GAIN;
            else if (tgt == idle_thr) cur += thr_inc * THR_RETURN_GAIN;
            else cur += step;
            if (cur > tgt) cur = tgt;
            if (tgt > idle_thr && cur > idle_thr && cur < idle_thr + thr_band)
                cur = idle_thr + thr_band;
            cur = clamp_pct(cur);
        end else if (tgt < cur) begin
            r.throttle_moved = 1'b1;
            if (cur > idle_thr && tgt < idle_thr) cur -= thr_inc * THR_CROSS_GAIN;
            else if (tgt == idle_thr) cur -= thr_inc * THR_RETURN_GAIN;
            else cur -= step;
            if (cur < tgt) cur = tgt;
            if (tgt < idle_thr && cur < idle_thr && cur > idle_thr - thr_band)
                cur = idle_thr - thr_band;
            cur = clamp_pct(cur);
        end
        thr_pos = cur;

        // steering: scaled down by the updated throttle deflection
        dev = thr_pos - idle_thr;
        if (dev < 0) dev = -dev;
        den = 2 * thr_span;
        num = den - dev;
        if (den == 0) begin
            num = (dev == 0) ? 1 : 0;
            den = 1;
        end else if (num < 0) begin
            num = 0;
        end

        tgt = aim_point(cmd.raw_steering, idle_str, str_span);
        cur = str_pos;
        if (tgt > cur) begin
            r.steering_moved = 1'b1;
            if (cur < idle_str && tgt > idle_str) cur += (str_inc * STR_CROSS_GAIN * num) / den;
            else cur += (str_inc * num) / den;
            if (cur > tgt) cur = tgt;
        end else if (tgt < cur) begin
            r.steering_moved = 1'b1;
            if (cur > idle_str && tgt < idle_str) cur -= (str_inc * STR_CROSS_GAIN * num) / den;
            else cur -= (str_inc * num) / den;
            if (cur < tgt) cur = tgt;
        end else begin
            r.steering_release = !str_settled;
            str_settled = 1'b1;
        end
        if (r.steering_moved) str_settled = 1'b0;
        str_pos = clamp_pct(cur);

        r.throttle_position = thr_pos[POS_W-1:0];
        r.steering_position = str_pos[POS_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string what, logic [POS_W-1:0] want,
                                        logic [POS_W-1:0] got);
        if (got !== want) begin
            errors++;
            if (reports < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            reports++;
        end
    endfunction

    function automatic void push_cmd(int st, int th);
        t_in_item c;
        c.raw_steering = st[RAW_W-1:0];
        c.raw_throttle = th[RAW_W-1:0];
        cmd_queue.push_back(c);
    endfunction

    function automatic int pick_raw();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 99;
            2, 3:    return 50;
            default: return $urandom_range(0, 99);
        endcase
    endfunction

    // mostly held commands so positions converge and settle, with some noise
    function automatic void queue_runs(int count);
        int pushed, kind, len, st, th;
        pushed = 0;
        while (pushed < count) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                st  = pick_raw();
                th  = pick_raw();
                len = $urandom_range(1, 24);
                for (int k = 0; k < len; k++) push_cmd(st, th);
            end else if (kind <= 8) begin
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++)
                    push_cmd($urandom_range(0, 99), $urandom_range(0, 99));
            end else begin
                len = 1;
                push_cmd($urandom_range(0, 127), $urandom_range(100, 127));
            end
            pushed += len;
        end
    endfunction

    task automatic program_setup(int idle_t, int idle_s, int t_span, int band,
                                 int s_span, int t_inc, int s_inc);
        int vals [7];
        vals = '{idle_t, idle_s, t_span, band, s_span, t_inc, s_inc};
        for (int k = 0; k < 7; k++) begin
            @(negedge i_clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= SETUP_ORDER[k];
            cfg_data <= vals[k][CFG_DATA_W-1:0];
            case (SETUP_ORDER[k])
                CFG_IDLE_THROTTLE:      idle_thr = longint'(vals[k][POS_W-1:0]);
                CFG_IDLE_STEERING:      idle_str = longint'(vals[k][POS_W-1:0]);
                CFG_THROTTLE_SPAN:      thr_span = longint'(vals[k][SPAN_W-1:0]);
                CFG_THROTTLE_DEAD_BAND: thr_band = longint'(vals[k][SPAN_W-1:0]);
                CFG_STEERING_SPAN:      str_span = longint'(vals[k][SPAN_W-1:0]);
                CFG_THROTTLE_INCREMENT: thr_inc  = longint'(vals[k][INC_W-1:0]);
                CFG_STEERING_INCREMENT: str_inc  = longint'(vals[k][INC_W-1:0]);
                default: ;
            endcase
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        n_phases++;
    endtask

    task automatic wait_quiet();
        do @(posedge i_clk);
        while (cmd_queue.size() != 0 || in_valid || expected_positions.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // driver: bursts of transactions with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (cmd_queue.size() > 0) begin
                in_valid <= 1'b1;
                in_data  <= cmd_queue.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= $urandom_range(0, 1) ? $urandom_range(1, 250) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern, plus a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_done != hold_asked) begin
            hold_done <= hold_done + 1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
                rx_left <= $urandom_range(50, 600);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= (rx_left % 16 == 0);
                default:   out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // monitor: predicts on input transactions, checks output transactions
    always @(posedge i_clk) begin
        t_out_item want;
        in_taken <= i_rst_n && in_valid && in_ready;
        if (i_rst_n && out_valid && out_ready) begin
            n_results++;
            if (expected_positions.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, out_data);
            end else begin
                want = expected_positions.pop_front();
                check_field("throttle_position", want.throttle_position,
                            out_data.throttle_position);
                check_field("steering_position", want.steering_position,
                            out_data.steering_position);
                check_field("throttle_moved", POS_W'(want.throttle_moved),
                            POS_W'(out_data.throttle_moved));
                check_field("steering_moved", POS_W'(want.steering_moved),
                            POS_W'(out_data.steering_moved));
                check_field("steering_release", POS_W'(want.steering_release),
                            POS_W'(out_data.steering_release));
            end
        end
        if (i_rst_n && in_valid && in_ready) begin
            want = slew_step(in_data);
            expected_positions.push_back(want);
            n_cmds++;
            n_thr_moves += int'(want.throttle_moved);
            n_str_moves += int'(want.steering_moved);
            n_releases  += int'(want.steering_release);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("servo_throttle_steering_ramp_test: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: idle, full deflection, crossings, return to idle,
        // raw above 99, and steering settling for a release pulse
        push_cmd(50, 50);  push_cmd(99, 99);  push_cmd(99, 99);  push_cmd(0, 0);
        push_cmd(0, 0);    push_cmd(50, 50);  push_cmd(50, 50);  push_cmd(127, 127);
        push_cmd(100, 64); push_cmd(0, 99);   push_cmd(99, 0);   push_cmd(1, 98);
        push_cmd(49, 51);  push_cmd(51, 49);  push_cmd(50, 50);  push_cmd(50, 50);
        push_cmd(50, 50);  push_cmd(50, 50);  push_cmd(64, 63);  push_cmd(50, 50);
        push_cmd(50, 50);  push_cmd(50, 50);
        wait_quiet();

        // fast slew; receiver held off until the block backs up
        program_setup(12800, 12544, 2304, 2304, 3072, 640, 1200);
        queue_runs(120);
        hold_asked = hold_asked + 1;
        wait_quiet();

        // lower extremes
        program_setup(0, 0, 1, 0, 0, 0, 0);
        queue_runs(40);
        wait_quiet();

        // upper extremes
        program_setup(25600, 25600, 12800, 12800, 12800, 2560, 2560);
        queue_runs(40);
        wait_quiet();

        // zero throttle span
        program_setup(12800, 12800, 0, 256, 6400, 300, 500);
        queue_runs(40);
        wait_quiet();

        // idle beyond full scale
        program_setup(30000, 32767, 2304, 2304, 3072, 200, 400);
        queue_runs(40);
        wait_quiet();

        for (int p = 0; p < 6; p++) begin
            program_setup($urandom_range(0, 25600), $urandom_range(0, 25600),
                          $urandom_range(1, 12800), $urandom_range(0, 12800),
                          $urandom_range(0, 12800), $urandom_range(0, 2560),
                          $urandom_range(0, 2560));
            queue_runs(100);
            wait_quiet();
        end

        $display("%0d commands in, %0d results checked over %0d setup phases",
                 n_cmds, n_results, n_phases + 1);
        $display("throttle moves %0d, steering moves %0d, steering releases %0d",
                 n_thr_moves, n_str_moves, n_releases);
        if (errors == 0) begin
            $display("servo_throttle_steering_ramp_test: done, clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("servo_throttle_steering_ramp_test: done, errors");
        end
        $finish;
    end

endmodule
